// File: design/pdlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdlr_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SAMPLE_FORMAT   = 3'd0;
    localparam logic [2:0] REG_BITS_PER_SAMPLE = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd2;
    localparam logic [2:0] REG_STEP_RATIO      = 3'd3;
    localparam logic [2:0] REG_MAX_FRAMES      = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Sample formats
    localparam logic FMT_INT   = 1'b0;
    localparam logic FMT_FLOAT = 1'b1;

    localparam logic [5:0] BPS_8  = 6'd8;
    localparam logic [5:0] BPS_16 = 6'd16;
    localparam logic [5:0] BPS_24 = 6'd24;
    localparam logic [5:0] BPS_32 = 6'd32;

    localparam logic [1:0] CHN_STEREO = 2'd2;
    localparam logic [20:0] MIN_STEP  = 21'd1024;

    localparam logic [15:0] Q15_POS_MAX = 16'sd32767;
    localparam logic [15:0] Q15_NEG_MAX = -16'sd32767;
    localparam logic [14:0] FLT_SCALE   = 15'd32767;
    localparam logic [7:0]  FLT_EXP_ONE = 8'd127;
    localparam logic [7:0]  FLT_EXP_MAX = 8'd255;
    localparam logic [7:0]  FLT_SH_BASE = 8'd150;

    // Decoder setup shared by all lanes
    typedef struct packed {
        logic       sample_format;
        logic [5:0] bits_per_sample;
    } t_dec_cfg;

endpackage
`default_nettype wire

// File: design/pdlr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pdlr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_left;
    logic [31:0] raw_right;
    logic        first_frame;
    modport source (output valid, output raw_left, output raw_right, output first_frame,
                    input ready);
    modport sink (input valid, input raw_left, input raw_right, input first_frame,
                  output ready);
endinterface
`default_nettype wire

// File: design/pdlr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pdlr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               last_of_run;
    logic               limit_reached;
    modport source (output valid, output out_left, output out_right, output last_of_run,
                    output limit_reached, input ready);
    modport sink (input valid, input out_left, input out_right, input last_of_run,
                  input limit_reached, output ready);
endinterface
`default_nettype wire

// File: design/pdlr_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pdlr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: design/pcm_decode_linear_resampler.sv
`timescale 1ns / 1ps
`default_nettype none
// PCM decode and linear-interpolation resampler, Q15 output.
// i_in carries one source frame per transfer (raw word per channel plus a
// restart flag); o_out carries interpolated output frames; i_cfg writes the
// five setup registers and is always ready. Write setup only while idle.
// Each channel has its own decode lane (two-stage float/PCM decoder) and
// interpolator; the output register merges the lanes into one frame.
// An input frame passes through capture, two decode stages and evaluate;
// a frame that follows held history then enters a run state that emits its
// output frames, skips positions after MAX_RUN outputs and closes by storing
// the frame as history; i_in.ready is high only between frames.
// Output frames leave one per cycle while the sink keeps ready high; when
// the sink stalls, the frame holds in the output register and the run
// pauses. The first frame after reset or a restart only primes history.
// Reset clears setup to its defaults, history, position and counts.
module pcm_decode_linear_resampler #(
    parameter int CHANNELS = 2,
    parameter int MAX_RUN  = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pdlr_in_if.sink    i_in,
    pdlr_out_if.source o_out,
    pdlr_cfg_if.sink   i_cfg
);
    import pdlr_pkg::*;

    localparam int RUN_W = $clog2(MAX_RUN + 1);
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_RUN);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_D1   = 3'd1;
    localparam logic [2:0] ST_D2   = 3'd2;
    localparam logic [2:0] ST_EVAL = 3'd3;
    localparam logic [2:0] ST_RUN  = 3'd4;

    logic        r_fmt;
    logic [5:0]  r_bps;
    logic [1:0]  r_chn;
    logic [20:0] r_step;
    logic [23:0] r_max;

    logic [2:0]          r_state;
    logic [31:0]         r_raw [CHANNELS];
    logic                r_first;
    logic signed [15:0]  r_prev [CHANNELS];
    logic                r_have;
    logic [31:0]         r_idx;
    logic [47:0]         r_pos;
    logic [23:0]         r_count;
    logic [RUN_W-1:0]    r_n;

    logic               r_ovalid;
    logic signed [15:0] r_oleft, r_oright;
    logic               r_olast, r_olimit;

    t_dec_cfg           w_dcfg;
    logic signed [15:0] w_dec [CHANNELS];
    logic signed [15:0] w_cur [CHANNELS];
    logic signed [15:0] w_lerp [CHANNELS];
    logic signed [15:0] w_right;
    logic               w_stereo;
    logic [20:0]        w_step;
    logic [47:0]        w_pos_next;
    logic               w_cond, w_next_cond, w_slot, w_emit;
    logic [23:0]        w_count_next;
    logic [RUN_W-1:0]   w_n_next;

    assign w_dcfg.sample_format   = r_fmt;
    assign w_dcfg.bits_per_sample = r_bps;
    assign w_stereo = (r_chn == CHN_STEREO) && (CHANNELS >= 2);
    assign w_step   = (r_step < MIN_STEP) ? MIN_STEP : r_step;

    // Per-channel decode and interpolation lanes
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (i_in.valid && i_in.ready) begin
                r_raw[c] <= (c == 0) ? i_in.raw_left : i_in.raw_right;
            end
        end
        pdlr_decode u_dec (
            .i_clk (i_clk),
            .i_cfg (w_dcfg),
            .i_raw (r_raw[c]),
            .o_val (w_dec[c])
        );
        assign w_cur[c] = (c > 0 && !w_stereo) ? 16'sd0 : w_dec[c];
        pdlr_lerp u_lerp (
            .i_a    (r_prev[c]),
            .i_b    (w_cur[c]),
            .i_frac (r_pos[15:0]),
            .o_val  (w_lerp[c])
        );
    end

    if (CHANNELS >= 2) begin : g_right
        assign w_right = w_stereo ? w_lerp[CHANNELS-1] : 16'sd0;
    end else begin : g_mono
        assign w_right = 16'sd0;
    end

    // Run control: current and following position test
    assign w_pos_next   = r_pos + 48'(w_step);
    assign w_count_next = r_count + 24'd1;
    assign w_n_next     = r_n + RUN_W'(1);
    assign w_cond       = (r_n < RUN_MAX) && (r_count < r_max) && (r_pos[47:16] == r_idx);
    assign w_next_cond  = (w_n_next < RUN_MAX) && (w_count_next < r_max)
                          && (w_pos_next[47:16] == r_idx);
    assign w_slot       = !r_ovalid || o_out.ready;
    assign w_emit       = (r_state == ST_RUN) && w_cond && w_slot;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // Setup registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= FMT_INT;
            r_bps  <= BPS_16;
            r_chn  <= 2'd1;
            r_step <= 21'd65536;
            r_max  <= 24'hFFFFFF;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SAMPLE_FORMAT:   r_fmt  <= i_cfg.data[0];
                REG_BITS_PER_SAMPLE: r_bps  <= i_cfg.data[5:0];
                REG_CHANNEL_COUNT:   r_chn  <= i_cfg.data[1:0];
                REG_STEP_RATIO:      r_step <= i_cfg.data[20:0];
                REG_MAX_FRAMES:      r_max  <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

    // Sequencer and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_have  <= 1'b0;
            r_idx   <= '0;
            r_pos   <= '0;
            r_count <= '0;
            r_n     <= '0;
            r_first <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_prev[c] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_first <= i_in.first_frame;
                        r_state <= ST_D1;
                    end
                end
                ST_D1: r_state <= ST_D2;
                ST_D2: r_state <= ST_EVAL;
                ST_EVAL: begin
                    r_n <= '0;
                    if (r_first || !r_have) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_prev[c] <= w_cur[c];
                        end
                        r_have  <= 1'b1;
                        r_idx   <= '0;
                        r_pos   <= '0;
                        r_count <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_cond) begin
                        if (w_slot) begin
                            r_pos   <= w_pos_next;
                            r_count <= w_count_next;
                            r_n     <= w_n_next;
                        end
                    end else if (r_n == RUN_MAX && r_pos[47:16] == r_idx) begin
                        // skip positions past the run limit
                        r_pos <= w_pos_next;
                    end else begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_prev[c] <= w_cur[c];
                        end
                        r_idx   <= r_idx + 32'd1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register merges the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_oleft  <= w_lerp[0];
            r_oright <= w_right;
            r_olast  <= !w_next_cond;
            r_olimit <= (w_count_next == r_max);
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.out_left      = r_oleft;
    assign o_out.out_right     = r_oright;
    assign o_out.last_of_run   = r_olast;
    assign o_out.limit_reached = r_olimit;
endmodule
`default_nettype wire

// File: design/pdlr_decode.sv
`timescale 1ns / 1ps
`default_nettype none
module pdlr_decode (
    input  wire logic               i_clk,
    input  wire pdlr_pkg::t_dec_cfg i_cfg,
    input  wire logic [31:0]        i_raw,
    output logic signed [15:0]      o_val
);
    import pdlr_pkg::*;

    logic               r_is_flt, n_is_flt;
    logic signed [15:0] r_val, n_val;
    logic               r_sign;
    logic [7:0]         r_ex;
    logic [38:0]        r_prod;
    logic signed [15:0] r_out, n_out;

    logic [7:0]  w_ex;
    logic [22:0] w_fr;
    logic [24:0] w_q;
    logic        w_up;
    logic [39:0] w_rounded;
    logic [7:0]  w_sh;
    logic [39:0] w_shifted;
    logic [15:0] w_mag;

    assign w_ex = i_raw[30:23];
    assign w_fr = i_raw[22:0];

    // Stage one: integer formats and float special cases, float mantissa product
    always_comb begin
        n_is_flt = 1'b0;
        n_val    = '0;
        if (i_cfg.sample_format == FMT_INT) begin
            case (i_cfg.bits_per_sample)
                BPS_8:   n_val = {i_raw[7:0] ^ 8'h80, 8'h00};
                BPS_16:  n_val = i_raw[15:0];
                BPS_24:  n_val = i_raw[23:8];
                BPS_32:  n_val = i_raw[31:16];
                default: n_val = '0;
            endcase
        end else if (i_cfg.bits_per_sample == BPS_32) begin
            if (w_ex == FLT_EXP_MAX && w_fr != '0) begin
                n_val = '0;
            end else if (w_ex >= FLT_EXP_ONE) begin
                n_val = i_raw[31] ? Q15_NEG_MAX : Q15_POS_MAX;
            end else if (w_ex != '0) begin
                n_is_flt = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_flt <= n_is_flt;
        r_val    <= n_val;
        r_sign   <= i_raw[31];
        r_ex     <= w_ex;
        r_prod   <= {15'd0, 1'b1, w_fr} * {24'd0, FLT_SCALE};
    end

    // Stage two: round product to 24 significant bits, then scale down
    always_comb begin
        if (r_prod[38]) begin
            w_q  = {1'b0, r_prod[38:15]};
            w_up = r_prod[14] && ((r_prod[13:0] != '0) || r_prod[15]);
        end else begin
            w_q  = {1'b0, r_prod[37:14]};
            w_up = r_prod[13] && ((r_prod[12:0] != '0) || r_prod[14]);
        end
        w_q = w_q + {24'd0, w_up};
        w_rounded = r_prod[38] ? {w_q, 15'd0} : {1'b0, w_q, 14'd0};
        w_sh = FLT_SH_BASE - r_ex;
        w_shifted = (w_sh >= 8'd40) ? '0 : (w_rounded >> w_sh[5:0]);
        w_mag = w_shifted[15:0];
        n_out = r_is_flt ? (r_sign ? -w_mag : w_mag) : r_val;
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_val = r_out;
endmodule
`default_nettype wire

// File: design/pdlr_lerp.sv
`timescale 1ns / 1ps
`default_nettype none
module pdlr_lerp (
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    input  wire logic [15:0]        i_frac,
    output logic signed [15:0]      o_val
);
    logic signed [16:0] w_diff;
    logic signed [33:0] w_prod;
    logic [33:0]        w_mag;
    logic signed [17:0] w_t;
    logic signed [17:0] w_sum;

    // Truncate the weighted difference toward zero, add, saturate
    always_comb begin
        w_diff = 17'(i_b) - 17'(i_a);
        w_prod = 34'(w_diff) * $signed({18'd0, i_frac});
        w_mag  = w_prod[33] ? 34'(-w_prod) : w_prod;
        w_t    = w_prod[33] ? -$signed({1'b0, w_mag[32:16]}) : $signed({1'b0, w_mag[32:16]});
        w_sum  = 18'(i_a) + w_t;
        if (w_sum > 18'sd32767) begin
            o_val = 16'sd32767;
        end else if (w_sum < -18'sd32768) begin
            o_val = -16'sd32768;
        end else begin
            o_val = w_sum[15:0];
        end
    end
endmodule
`default_nettype wire

// File: verif/tb_pdlr_ifs.sv
`timescale 1ns / 1ps
// The channel interfaces come with the design; this file only holds a
// shared type for the expected output frames.
package tb_pdlr_types;
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
        logic               limit;
    } t_frame;
endpackage

// File: verif/tb_pcm_decode_linear_resampler.sv
`timescale 1ns / 1ps
module tb_pcm_decode_linear_resampler;
    import pdlr_pkg::*;
    import tb_pdlr_types::*;

    localparam int RUN_CAP = 64;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pdlr_in_if  in_ch ();
    pdlr_out_if out_ch ();
    pdlr_cfg_if cfg_ch ();

    pcm_decode_linear_resampler u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow setup and interpolation state
    logic        fmt_q;
    logic [5:0]  bps_q;
    logic [1:0]  chn_q;
    logic [20:0] step_q;
    logic [23:0] maxf_q;
    int          hist_l, hist_r;
    bit          hist_ok;
    logic [31:0] src_idx;
    logic [47:0] pos_q;
    logic [23:0] made_q;

    typedef struct packed {
        logic [31:0] l;
        logic [31:0] r;
        logic        ff;
    } t_src;

    t_src   pending_src[$];
    t_frame expected_frames[$];
    int     errors = 0;
    int     frames_seen = 0;
    int     idle_cycles = 0;
    bit     in_go = 1'b0;
    bit     in_took = 1'b0;

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int flt_q15(logic [31:0] u);
        logic [7:0]  ex;
        logic [63:0] prod, q, rem, half;
        int          drop, sh, mag;
        ex = u[30:23];
        if (ex == 8'hFF && u[22:0] != 0) return 0;
        if (ex >= 8'd127) return u[31] ? -32767 : 32767;
        if (ex == 0) return 0;
        prod = 64'({1'b1, u[22:0]}) * 64'd32767;
        drop = (prod >> 38) != 0 ? 15 : 14;
        q = prod >> drop;
        rem = prod & ((64'd1 << drop) - 1);
        half = 64'd1 << (drop - 1);
        if (rem > half || (rem == half && q[0])) q++;
        sh = 150 - int'(ex);
        if (sh >= 63) return 0;
        mag = int'((q << drop) >> sh);
        return u[31] ? -mag : mag;
    endfunction

    function automatic int decode_word(logic [31:0] w);
        if (fmt_q == FMT_INT) begin
            case (bps_q)
                BPS_8:  return (int'(w[7:0]) - 128) * 256;
                BPS_16: return int'($signed(w[15:0]));
                BPS_24: return int'($signed(w[23:8]));
                BPS_32: return int'($signed(w[31:16]));
                default: return 0;
            endcase
        end
        if (bps_q == BPS_32) return flt_q15(w);
        return 0;
    endfunction

    function automatic logic [15:0] blend(int a, int b, logic [15:0] frac);
        longint p, t, r;
        p = longint'(b - a) * longint'(frac);
        t = (p >= 0) ? (p >>> 16) : -((-p) >>> 16);
        r = a + t;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Advance the shadow model by one accepted source frame
    task automatic predict_frames(t_src s);
        bit     stereo;
        int     cur_l, cur_r, n;
        logic [20:0] stp;
        t_frame f;
        stereo = (chn_q == CHN_STEREO);
        cur_l = decode_word(s.l);
        cur_r = stereo ? decode_word(s.r) : 0;
        stp = (step_q < MIN_STEP) ? MIN_STEP : step_q;
        n = 0;
        if (s.ff || !hist_ok) begin
            hist_l = cur_l; hist_r = cur_r; hist_ok = 1'b1;
            src_idx = 0; pos_q = 0; made_q = 0;
            return;
        end
        while (n < RUN_CAP && made_q < maxf_q && pos_q[47:16] == src_idx) begin
            f.left = blend(hist_l, cur_l, pos_q[15:0]);
            f.right = stereo ? blend(hist_r, cur_r, pos_q[15:0]) : 16'd0;
            made_q++;
            f.limit = (made_q == maxf_q);
            f.last = 1'b0;
            expected_frames.push_back(f);
            pos_q = pos_q + 48'(stp);
            n++;
        end
        if (n == RUN_CAP)
            while (pos_q[47:16] == src_idx) pos_q = pos_q + 48'(stp);
        if (n > 0) expected_frames[expected_frames.size() - 1].last = 1'b1;
        hist_l = cur_l; hist_r = cur_r;
        src_idx++;
    endtask

    // Source-frame driver: present pending frames, random gaps between transfers
    int in_gap = 0;
    always @(negedge i_clk) begin
        if (in_took) begin
            in_took = 1'b0;
            in_gap = gap_len();
        end
        if (in_go && pending_src.size() > 0 && in_gap == 0) begin
            in_ch.valid <= 1'b1;
            in_ch.raw_left <= pending_src[0].l;
            in_ch.raw_right <= pending_src[0].r;
            in_ch.first_frame <= pending_src[0].ff;
        end else begin
            in_ch.valid <= 1'b0;
            if (in_gap > 0) in_gap--;
        end
    end

    // Sink stalls
    int out_stall = 0;
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_ch.ready <= 1'b0;
            out_stall--;
        end else begin
            out_ch.ready <= 1'b1;
            out_stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        end
    end

    // Monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_frame got, want;
        bit     moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                predict_frames(pending_src.pop_front());
                in_took = 1'b1;
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                frames_seen <= frames_seen + 1;
                got = {out_ch.out_left, out_ch.out_right,
                       out_ch.last_of_run, out_ch.limit_reached};
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected output frame %h", $realtime, got);
                    errors++;
                end else begin
                    want = expected_frames.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected L=%0d R=%0d last=%b lim=%b",
                                 $realtime, want.left, want.right, want.last, want.limit);
                        $display("%0t:          actual   L=%0d R=%0d last=%b lim=%b",
                                 $realtime, got.left, got.right, got.last, got.limit);
                        errors++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Register write, held until accepted; mirror it into the shadow copy
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_SAMPLE_FORMAT:   fmt_q = val[0];
            REG_BITS_PER_SAMPLE: bps_q = val[5:0];
            REG_CHANNEL_COUNT:   chn_q = val[1:0];
            REG_STEP_RATIO:      step_q = val[20:0];
            REG_MAX_FRAMES:      maxf_q = val[23:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic setup(logic f, logic [5:0] b, logic [1:0] c, logic [20:0] s,
                         logic [23:0] m);
        write_reg(REG_SAMPLE_FORMAT, 24'(f));
        write_reg(REG_BITS_PER_SAMPLE, 24'(b));
        write_reg(REG_CHANNEL_COUNT, 24'(c));
        write_reg(REG_STEP_RATIO, 24'(s));
        write_reg(REG_MAX_FRAMES, m);
    endtask

    // Let the block drain, including skipped positions after a long run
    task automatic drain();
        in_go = 1'b1;
        wait (pending_src.size() == 0 && expected_frames.size() == 0);
        repeat (200) @(posedge i_clk);
        in_go = 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return {$urandom_range(0, 1) ? 9'h07F : 9'h17F,
                       23'($urandom())};
            3: return {1'($urandom()), 8'($urandom_range(100, 126)), 23'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    task automatic push_src(logic [31:0] l, logic [31:0] r, logic ff);
        pending_src.push_back('{l: l, r: r, ff: ff});
    endtask

    task automatic push_random(int count);
        for (int k = 0; k < count; k++)
            push_src(rand_word(), rand_word(), (k == 0) || ($urandom_range(0, 40) == 0));
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.raw_left = '0;
        in_ch.raw_right = '0;
        in_ch.first_frame = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        fmt_q = FMT_INT; bps_q = BPS_16; chn_q = 2'd1;
        step_q = 21'd65536; maxf_q = 24'hFFFFFF;
        hist_l = 0; hist_r = 0; hist_ok = 1'b0;
        src_idx = 0; pos_q = 0; made_q = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: 16-bit mono, unit step; no history yet
        push_src(32'h0000_7FFF, 32'h0, 1'b0);
        push_src(32'h0000_8000, 32'h0, 1'b0);
        push_src(32'h0000_0001, 32'h0, 1'b0);
        drain();

        // 8-bit stereo, fine up-sampling hits the run cap
        setup(FMT_INT, BPS_8, CHN_STEREO, 21'd1024, 24'hFFFFFF);
        push_src(32'h00, 32'hFF, 1'b1);
        push_src(32'hFF, 32'h00, 1'b0);
        push_src(32'h80, 32'h7F, 1'b0);
        drain();

        // 24-bit and 32-bit integer, step below minimum, output limit
        setup(FMT_INT, BPS_24, CHN_STEREO, 21'd5, 24'd3);
        push_src(32'h007F_FF00, 32'h0080_0000, 1'b1);
        push_src(32'h0080_0000, 32'h007F_FF00, 1'b0);
        push_src(32'h1234_5678, 32'h0, 1'b0);
        drain();
        write_reg(REG_BITS_PER_SAMPLE, 24'(BPS_32));
        write_reg(REG_STEP_RATIO, 24'h100000);
        write_reg(REG_MAX_FRAMES, 24'd0);
        push_src(32'h7FFF_0000, 32'h8000_0000, 1'b1);
        push_src(32'h8000_0000, 32'h7FFF_0000, 1'b0);
        drain();

        // Float: clamps, infinities, NaN, subnormal; then unsupported width
        setup(FMT_FLOAT, BPS_32, CHN_STEREO, 21'd40000, 24'hFFFFFF);
        push_src(32'h3F80_0000, 32'hBF80_0000, 1'b1);
        push_src(32'h7F80_0000, 32'hFF80_0000, 1'b0);
        push_src(32'h7FC0_0000, 32'h0000_0001, 1'b0);
        push_src(32'h3F00_0000, 32'hBEAA_AAAB, 1'b0);
        push_src(32'h4000_0000, 32'h3380_0000, 1'b0);
        drain();
        write_reg(REG_BITS_PER_SAMPLE, 24'd20);
        push_src(32'h1234_5678, 32'h8765_4321, 1'b0);
        push_src(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        drain();

        // Random phases over a spread of setups
        setup(FMT_INT, BPS_16, 2'd1, 21'd30000, 24'hFFFFFF);
        push_random(35);
        drain();
        setup(FMT_FLOAT, BPS_32, CHN_STEREO, 21'd90000, 24'hFFFFFF);
        push_random(35);
        drain();
        setup(FMT_INT, BPS_24, CHN_STEREO, 21'h1FFFFF, 24'hFFFFFF);
        push_random(25);
        drain();
        setup(FMT_INT, BPS_8, 2'd3, 21'd3000, 24'd40);
        push_random(25);
        drain();
        setup(FMT_INT, BPS_32, CHN_STEREO,
              21'($urandom_range(1024, 1048576)), 24'($urandom_range(20, 200)));
        push_random(32);
        drain();

        $display("covered %0d output frames across PCM 8/16/24/32, float and",
                 frames_seen);
        $display("unsupported formats, mono/stereo, run cap and frame limit");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
